### rtl/bdel_pkg.sv
// Package for the bounded double-ended list: sizes, command and status codes,
// memory request and response types, ring slot arithmetic.
// No dependencies.
package bdel_pkg;

	localparam int CAPACITY  = 256;
	localparam int ELEM_W    = 32;
	localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int CMP_W     = (CNT_W > 9) ? CNT_W : 9;
	localparam int POS_W     = 8;
	localparam int SIZE_W    = 9;
	localparam int CMD_W     = 3;
	localparam int STATUS_W  = 2;
	localparam int ELEM_IN_W = 32;
	localparam int S_DATA_W  = 40;
	localparam int M_DATA_W  = 48;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [ELEM_W-1:0] elem_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_HEAD = 3'd0,
		CMD_PUSH_TAIL = 3'd1,
		CMD_POP_HEAD  = 3'd2,
		CMD_POP_TAIL  = 3'd3,
		CMD_READ_HEAD = 3'd4,
		CMD_READ_TAIL = 3'd5,
		CMD_READ_POS  = 3'd6,
		CMD_NONE      = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		elem_t wdata;
		logic  re;
		addr_t raddr;
	} ram_req_t;

	typedef struct packed {
		logic              rd;
		logic [SIZE_W-1:0] size;
		status_t           status;
	} resp_t;

	function automatic addr_t slot_add(addr_t a, addr_t b);
		logic [ADDR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (ADDR_W+1)'(CAPACITY))
			s = s - (ADDR_W+1)'(CAPACITY);
		return s[ADDR_W-1:0];
	endfunction

endpackage

### rtl/bdel_ram.sv
// Single-port-write, single-port-read synchronous element store.
// Read data registered. No dependencies.
module bdel_ram #(
	parameter int DEPTH  = 256,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### rtl/bdel_ctrl.sv
// Head pointer and element count, command decode, store access generation.
// Depends on bdel_pkg.
module bdel_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [bdel_pkg::CMD_W-1:0]   cmd,
	input  logic [bdel_pkg::ELEM_IN_W-1:0] element_in,
	input  logic [bdel_pkg::POS_W-1:0]   position,
	output bdel_pkg::ram_req_t           ram_req,
	output bdel_pkg::resp_t              resp
);
	import bdel_pkg::*;

	addr_t  head_q;
	count_t count_q;
	addr_t  head_nx;
	count_t count_nx;
	addr_t  head_m1;
	count_t cnt_m1;
	logic   full;
	logic   empty;
	logic   pos_over;
	elem_t  elem;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign cnt_m1   = count_q - CNT_W'(1);
	assign head_m1  = (head_q == '0) ? ADDR_W'(CAPACITY - 1) : head_q - ADDR_W'(1);
	assign pos_over = (CMP_W'(position) >= CMP_W'(count_q));
	assign elem     = ELEM_W'(element_in);

	always_comb begin
		head_nx       = head_q;
		count_nx      = count_q;
		ram_req.we    = 1'b0;
		ram_req.waddr = head_q;
		ram_req.wdata = elem;
		ram_req.re    = 1'b0;
		ram_req.raddr = head_q;
		resp.rd       = 1'b0;
		resp.status   = ST_OK;
		unique case (cmd_t'(cmd))
			CMD_PUSH_HEAD: begin
				if (full) begin
					resp.status = ST_FULL;
				end else begin
					head_nx       = head_m1;
					count_nx      = count_q + CNT_W'(1);
					ram_req.we    = accept;
					ram_req.waddr = head_m1;
				end
			end
			CMD_PUSH_TAIL: begin
				if (full) begin
					resp.status = ST_FULL;
				end else begin
					count_nx      = count_q + CNT_W'(1);
					ram_req.we    = accept;
					ram_req.waddr = slot_add(head_q, count_q[ADDR_W-1:0]);
				end
			end
			CMD_POP_HEAD: begin
				if (empty) begin
					resp.status = ST_EMPTY;
				end else begin
					head_nx  = slot_add(head_q, ADDR_W'(1));
					count_nx = cnt_m1;
				end
			end
			CMD_POP_TAIL: begin
				if (empty)
					resp.status = ST_EMPTY;
				else
					count_nx = cnt_m1;
			end
			CMD_READ_HEAD: begin
				if (empty) begin
					resp.status = ST_EMPTY;
				end else begin
					resp.rd       = 1'b1;
					ram_req.re    = accept;
					ram_req.raddr = head_q;
				end
			end
			CMD_READ_TAIL: begin
				if (empty) begin
					resp.status = ST_EMPTY;
				end else begin
					resp.rd       = 1'b1;
					ram_req.re    = accept;
					ram_req.raddr = slot_add(head_q, cnt_m1[ADDR_W-1:0]);
				end
			end
			CMD_READ_POS: begin
				if (empty) begin
					resp.status = ST_EMPTY;
				end else if (pos_over) begin
					resp.status = ST_RANGE;
				end else begin
					resp.rd       = 1'b1;
					ram_req.re    = accept;
					ram_req.raddr = slot_add(head_q, ADDR_W'(position));
				end
			end
			default: begin
			end
		endcase
		resp.size = SIZE_W'(count_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_nx;
			count_q <= count_nx;
		end
	end

endmodule

### rtl/bounded_double_ended_list.sv
// Bounded double-ended list top level: command port, control, element store,
// read stage and output register. Depends on bdel_pkg, bdel_ctrl, bdel_ram.
//
// channel  dir  tdata (low bit up)                 tuser
// s_*      in   element_in[31:0], position[39:32]  cmd[2:0]
// m_*      out  element_out[31:0], size_now[40:32] status[1:0]
//
// One command per cycle while s_tready is high; each result is registered in the
// read stage (the store's read port) and then in the output register.
// Reset clears head pointer, count and the valid flags only; the store needs no clearing pass.
// A stalled output holds the read stage, which in turn holds s_tready low.
module bounded_double_ended_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [bdel_pkg::S_DATA_W-1:0] s_tdata,  // element_in, position
	input  logic [bdel_pkg::CMD_W-1:0]    s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [bdel_pkg::M_DATA_W-1:0] m_tdata,  // element_out, size_now, pad
	output logic [bdel_pkg::STATUS_W-1:0] m_tuser   // status
);
	import bdel_pkg::*;

	ram_req_t ram_req;
	resp_t    resp;
	resp_t    resp_s1;
	logic     valid_s1;
	elem_t    rdata;
	logic     accept;
	logic     out_free;
	logic     out_valid_q;
	logic [ELEM_IN_W-1:0] out_elem_q;
	logic [SIZE_W-1:0]    out_size_q;
	status_t              out_status_q;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	bdel_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (s_tuser),
		.element_in (s_tdata[ELEM_IN_W-1:0]),
		.position   (s_tdata[ELEM_IN_W+POS_W-1:ELEM_IN_W]),
		.ram_req    (ram_req),
		.resp       (resp)
	);

	bdel_ram #(
		.DEPTH  (CAPACITY),
		.WIDTH  (ELEM_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (out_free)
				valid_s1 <= 1'b0;
			if (out_free)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			resp_s1 <= resp;
		if (out_free && valid_s1) begin
			out_elem_q   <= resp_s1.rd ? ELEM_IN_W'(rdata) : '0;
			out_size_q   <= resp_s1.size;
			out_status_q <= resp_s1.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W-ELEM_IN_W-SIZE_W){1'b0}}, out_size_q, out_elem_q};
	assign m_tuser  = out_status_q;

`ifndef ASSERT_OFF
	a_full_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |-> m_tdata[ELEM_IN_W+SIZE_W-1:ELEM_IN_W] == SIZE_W'(CAPACITY))
		else $error("full status with size below capacity");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> m_tdata[ELEM_IN_W-1:0] == '0)
		else $error("element returned on error");
	a_size_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[ELEM_IN_W+SIZE_W-1:ELEM_IN_W] <= SIZE_W'(CAPACITY))
		else $error("size beyond capacity");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |-> !s_tready)
		else $error("beat taken while read stage stalled");
`endif

endmodule
